// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL files of the fan voltage regulator.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/fvir_pkg.sv =====
// Package for the fan voltage integral regulator: widths, constants and the
// ramp coefficient table. Depends on nothing.
`timescale 1ns / 1ps

package fvir_pkg;

  localparam int ADC_W      = 12;
  localparam int PERIOD_W   = 16;
  localparam int TEMP_W     = 16;
  localparam int INTEG_W    = 17;

  localparam int INTEG_LIMIT    = 4095 * 10;
  localparam int SCALE_SHIFT    = 12;
  localparam int START_LEVEL    = 1500;
  localparam int DEG_LOW        = 30;
  localparam int DEG_HIGH       = 60;
  localparam int DEG_SPAN       = DEG_HIGH - DEG_LOW;
  localparam int PWM_PERIOD_RST = 4095;

  // Fixed-point reciprocal of the ramp span, scaled by the degree offset.
  localparam int RAMP_SHIFT = 20;
  localparam int RAMP_ONE   = 1 << RAMP_SHIFT;
  localparam int COEF_W     = RAMP_SHIFT + 1;
  localparam int COEF_N     = 32;

  typedef logic [COEF_W-1:0] coef_tab_t [COEF_N];

  // Per-unit control: load commits state, sel marks that this unit owns the item.
  typedef struct packed {
    logic load;
    logic sel;
  } unit_ctrl_t;

  // Entry d is ceil(d * 2^20 / 30), so (x * entry) >> 20 equals floor(x * d / 30)
  // for every x below 2595 + 1.
  function automatic coef_tab_t build_coef();
    coef_tab_t t;
    for (int i = 0; i < COEF_N; i++) begin
      t[i] = COEF_W'((i * RAMP_ONE + DEG_SPAN - 1) / DEG_SPAN);
    end
    return t;
  endfunction

  localparam coef_tab_t RAMP_COEF = build_coef();

endpackage

// ===== rtl/core/fvir_in_if.sv =====
// Input channel of the fan voltage regulator: valid/ready plus one item.
// Depends on fvir_pkg for field widths.
`timescale 1ns / 1ps

interface fvir_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  cmd;
  logic        [fvir_pkg::ADC_W-1:0]     adc_supply;
  logic        [fvir_pkg::ADC_W-1:0]     adc_fan_low;
  logic signed [fvir_pkg::TEMP_W-1:0]    temp_raw;
  logic                                  temp_valid;

  modport source (
    output valid, cmd, adc_supply, adc_fan_low, temp_raw, temp_valid,
    input  ready
  );
  modport sink (
    input  valid, cmd, adc_supply, adc_fan_low, temp_raw, temp_valid,
    output ready
  );
endinterface

// ===== rtl/core/fvir_out_if.sv =====
// Result channel of the fan voltage regulator: valid/ready plus one result.
// Depends on fvir_pkg for field widths.
`timescale 1ns / 1ps

interface fvir_out_if;
  logic                              valid;
  logic                              ready;
  logic [fvir_pkg::PERIOD_W-1:0]     pwm_compare;
  logic [fvir_pkg::ADC_W-1:0]        setpoint;

  modport source (
    output valid, pwm_compare, setpoint,
    input  ready
  );
  modport sink (
    input  valid, pwm_compare, setpoint,
    output ready
  );
endinterface

// ===== rtl/core/fvir_regulate.sv =====
// Integrator with saturation and PWM compare scaling for regulate steps.
// Depends on fvir_pkg.
`timescale 1ns / 1ps

module fvir_regulate (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fvir_pkg::unit_ctrl_t              ctrl,
  input  logic [fvir_pkg::ADC_W-1:0]        adc_supply,
  input  logic [fvir_pkg::ADC_W-1:0]        adc_fan_low,
  input  logic [fvir_pkg::ADC_W-1:0]        target_level,
  input  logic [fvir_pkg::PERIOD_W-1:0]     pwm_period,
  output logic [fvir_pkg::PERIOD_W-1:0]     compare_after,
  output logic [fvir_pkg::PERIOD_W-1:0]     compare_held
);

  localparam logic signed [17:0] LIM = 18'(fvir_pkg::INTEG_LIMIT);

  logic signed [fvir_pkg::INTEG_W-1:0] integ_r;
  logic signed [fvir_pkg::INTEG_W-1:0] integ_nxt;
  logic [fvir_pkg::PERIOD_W-1:0]       cmp_r;
  logic [fvir_pkg::PERIOD_W-1:0]       cmp_nxt;

  logic [12:0]        diff;
  logic [11:0]        volts;
  logic signed [13:0] err;
  logic signed [17:0] sum;
  logic [12:0]        power;
  logic [27:0]        prod;

  always_comb begin
    diff  = {1'b0, adc_supply} - {1'b0, adc_fan_low};
    volts = diff[12] ? 12'd0 : diff[11:0];
    err   = $signed({2'b00, target_level}) - $signed({2'b00, volts});
    sum   = $signed({integ_r[16], integ_r}) + $signed({{4{err[13]}}, err});

    if (sum > LIM) begin
      integ_nxt = LIM[16:0];
    end else if (sum < -LIM) begin
      integ_nxt = 17'(-LIM);
    end else begin
      integ_nxt = sum[16:0];
    end

    // Power term is the integrator over eight; negative values give none.
    power = integ_nxt[16] ? 13'd0 : integ_nxt[15:3];
    prod  = {16'b0, power[11:0]} * {12'b0, pwm_period};
    // Anything above 4095 drives full scale.
    cmp_nxt = power[12] ? pwm_period : prod[27:fvir_pkg::SCALE_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      cmp_r   <= '0;
    end else if (ctrl.load) begin
      integ_r <= integ_nxt;
      cmp_r   <= cmp_nxt;
    end
  end

  assign compare_after = ctrl.sel ? cmp_nxt : cmp_r;
  assign compare_held  = cmp_r;

endmodule

// ===== rtl/core/fvir_setpoint.sv =====
// Temperature-to-setpoint curve and the target level register.
// Depends on fvir_pkg (constants and ramp coefficient table).
`timescale 1ns / 1ps

module fvir_setpoint (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fvir_pkg::unit_ctrl_t               ctrl,
  input  logic [fvir_pkg::ADC_W-1:0]         adc_supply,
  input  logic signed [fvir_pkg::TEMP_W-1:0] temp_raw,
  input  logic                               temp_valid,
  output logic [fvir_pkg::ADC_W-1:0]         level,
  output logic [fvir_pkg::ADC_W-1:0]         level_after
);

  localparam logic [10:0] DEG_LO_C = 11'(fvir_pkg::DEG_LOW);
  localparam logic [10:0] DEG_HI_C = 11'(fvir_pkg::DEG_HIGH);
  localparam logic [11:0] START_C  = 12'(fvir_pkg::START_LEVEL);

  logic [11:0] level_r;
  logic [11:0] level_nxt;

  logic [14:0]                    temp_pos;
  logic [10:0]                    deg;
  logic [10:0]                    deg_off;
  logic [fvir_pkg::COEF_W-1:0]    coef;
  logic [11:0]                    span;
  logic [32:0]                    prod;

  always_comb begin
    temp_pos = temp_raw[15] ? 15'd0 : temp_raw[14:0];
    deg      = temp_pos[14:4];
    deg_off  = deg - DEG_LO_C;
    coef     = fvir_pkg::RAMP_COEF[deg_off[4:0]];
    span     = adc_supply - START_C;
    prod     = {21'b0, span} * {12'b0, coef};

    // With a supply under the start level the ramp never drops below the
    // supply, so the clamp always yields the supply itself.
    if (!temp_valid) begin
      level_nxt = adc_supply;
    end else if (deg <= DEG_LO_C) begin
      level_nxt = '0;
    end else if (deg > DEG_HI_C) begin
      level_nxt = adc_supply;
    end else if (adc_supply < START_C) begin
      level_nxt = adc_supply;
    end else begin
      level_nxt = START_C + prod[fvir_pkg::RAMP_SHIFT +: 12];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= START_C;
    end else if (ctrl.load) begin
      level_r <= level_nxt;
    end
  end

  assign level       = level_r;
  assign level_after = ctrl.sel ? level_nxt : level_r;

endmodule

// ===== rtl/core/fan_voltage_integral_regulator_unit.sv =====
// Top level of the fan voltage integral regulator: input register, the two
// work units and the result register. Depends on fvir_pkg, the channel
// interfaces, fvir_regulate, fvir_setpoint and assert_macros.svh.
//
//   channel | direction | handshake     | payload
//   in_ch   | sink      | valid / ready | cmd, adc_supply, adc_fan_low, temp_raw, temp_valid
//   out_ch  | source    | valid / ready | pwm_compare, setpoint
//   cfg     | sink      | cfg_wr_en     | cfg_wr_data (pwm_period)
//
// Every item yields one result through the input register and then the result
// register, and a new item is taken in every cycle while results drain.
// The input register and the result register bound one combinational pass
// that includes the 12 x 16 compare scaling multiply.
// A stalled result holds the input register, which still takes an item the
// same cycle the result register frees up.
// Reset is synchronous and active low; it restores the period to 4095, the
// setpoint to 1500 and clears the integrator and the held compare value.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fan_voltage_integral_regulator_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  fvir_in_if.sink                        in_ch,
  fvir_out_if.source                     out_ch,
  input  logic                           cfg_wr_en,
  input  logic [fvir_pkg::PERIOD_W-1:0]  cfg_wr_data
);

  // Configuration register: the user must write it only while the block is idle; the block does not enforce this.
  logic [fvir_pkg::PERIOD_W-1:0] pwm_period_r;

  // Input register holding the item under work.
  logic                                 s1_valid_r;
  logic                                 s1_cmd_r;
  logic [fvir_pkg::ADC_W-1:0]           s1_supply_r;
  logic [fvir_pkg::ADC_W-1:0]           s1_fan_r;
  logic signed [fvir_pkg::TEMP_W-1:0]   s1_temp_r;
  logic                                 s1_tvalid_r;

  // Result register.
  logic                                 out_valid_r;
  logic [fvir_pkg::PERIOD_W-1:0]        out_cmp_r;
  logic [fvir_pkg::ADC_W-1:0]           out_level_r;

  logic                                 advance;
  logic                                 in_take;
  fvir_pkg::unit_ctrl_t                 reg_ctrl;
  fvir_pkg::unit_ctrl_t                 sp_ctrl;
  logic [fvir_pkg::ADC_W-1:0]           level_cur;
  logic [fvir_pkg::ADC_W-1:0]           level_after;
  logic [fvir_pkg::PERIOD_W-1:0]        cmp_after;
  logic [fvir_pkg::PERIOD_W-1:0]        cmp_held;

  // The item in the input register moves on whenever the result register
  // is empty or its content is being taken this cycle.
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  // A regulate step commits the integrator and compare value; a temperature
  // update commits the target level. The state of the other unit is held.
  assign reg_ctrl.sel  = !s1_cmd_r;
  assign reg_ctrl.load = advance && !s1_cmd_r;
  assign sp_ctrl.sel   = s1_cmd_r;
  assign sp_ctrl.load  = advance && s1_cmd_r;

  fvir_regulate u_regulate (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (reg_ctrl),
    .adc_supply    (s1_supply_r),
    .adc_fan_low   (s1_fan_r),
    .target_level  (level_cur),
    .pwm_period    (pwm_period_r),
    .compare_after (cmp_after),
    .compare_held  (cmp_held)
  );

  fvir_setpoint u_setpoint (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (sp_ctrl),
    .adc_supply  (s1_supply_r),
    .temp_raw    (s1_temp_r),
    .temp_valid  (s1_tvalid_r),
    .level       (level_cur),
    .level_after (level_after)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_period_r <= fvir_pkg::PERIOD_W'(fvir_pkg::PWM_PERIOD_RST);
    end else if (cfg_wr_en) begin
      pwm_period_r <= cfg_wr_data;
    end
  end

  // Input register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r    <= in_ch.cmd;
      s1_supply_r <= in_ch.adc_supply;
      s1_fan_r    <= in_ch.adc_fan_low;
      s1_temp_r   <= in_ch.temp_raw;
      s1_tvalid_r <= in_ch.temp_valid;
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload: both fields reflect the state after the item.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_cmp_r   <= cmp_after;
      out_level_r <= level_after;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pwm_compare = out_cmp_r;
  assign out_ch.setpoint    = out_level_r;

  // An item that cannot move on must stay in the input register.
  `ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_r && !advance, s1_valid_r)
  // An item that moves on always shows up as a pending result.
  `ASSERT_NEXT(a_result_loaded, clk, rst_n, advance, out_ch.valid)
  // A temperature update reports the compare value left by the last regulate step.
  `ASSERT_NEXT(a_cmp_held, clk, rst_n, advance && s1_cmd_r,
               out_ch.pwm_compare == $past(cmp_held))
  // An invalid sensor reading sets the target to the supply reading.
  `ASSERT_NEXT(a_bad_sensor, clk, rst_n, advance && s1_cmd_r && !s1_tvalid_r,
               out_ch.setpoint == $past(s1_supply_r))

endmodule
